/* hw/rtl/spurious_wake_limiter_top_assert.svh */
// Assertion helpers for the spurious wake limiter top level.
`ifndef SPURIOUS_WAKE_LIMITER_TOP_ASSERT_SVH
`define SPURIOUS_WAKE_LIMITER_TOP_ASSERT_SVH

// Check cons in the same cycle as ante.
`define SWL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define SWL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/swl_pkg.sv */
package swl_pkg;

  // Event codes
  localparam logic [2:0] ACT_BOOT   = 3'd0;
  localparam logic [2:0] ACT_TICK   = 3'd1;
  localparam logic [2:0] ACT_MOTION = 3'd2;
  localparam logic [2:0] ACT_BARREL = 3'd3;
  localparam logic [2:0] ACT_FAIL   = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] CFG_WAKE_MASK  = 3'd0;
  localparam logic [2:0] CFG_SENSOR_PIN = 3'd1;
  localparam logic [2:0] CFG_VALID_TIME = 3'd2;
  localparam logic [2:0] CFG_LIMIT      = 3'd3;
  localparam logic [2:0] CFG_WINDOW     = 3'd4;

  // Configuration reset values
  localparam logic [63:0] RST_WAKE_MASK  = 64'd0;
  localparam logic [5:0]  RST_SENSOR_PIN = 6'd8;
  localparam logic [15:0] RST_VALID_TIME = 16'd200;
  localparam logic [7:0]  RST_LIMIT      = 8'd3;
  localparam logic [31:0] RST_WINDOW     = 32'd30000;

  localparam logic [7:0] COUNT_MAX = 8'd255;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] now_ms;
    logic [63:0] rtc_ms;
    logic        cold_boot;
    logic        wake_by_gpio;
    logic        barrel_held;
    logic        tip_held;
    logic        sensor_asserted;
  } in_word_t;

  typedef struct packed {
    logic [63:0] wake_mask;
    logic        mask_written;
    logic        sensor_wake_on;
    logic [7:0]  spurious_total;
    logic        check_pending;
  } out_word_t;

  typedef struct packed {
    logic [63:0] wake_source_mask;
    logic [5:0]  sensor_pin;
    logic [15:0] validation_time;
    logic [7:0]  spurious_limit;
    logic [31:0] window_length;
  } cfg_t;

  typedef struct packed {
    logic        retained_valid;
    logic [63:0] window_start;
    logic [7:0]  wake_count;
    logic        sensor_enabled;
    logic        pending;
    logic [31:0] deadline;
  } state_t;

endpackage

/* hw/rtl/swl_in_if.sv */
interface swl_in_if;
  logic               valid;
  logic               ready;
  swl_pkg::in_word_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/swl_out_if.sv */
interface swl_out_if;
  logic               valid;
  logic               ready;
  swl_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/swl_step.sv */
module swl_step (
  input  swl_pkg::in_word_t  item,
  input  swl_pkg::state_t    st,
  input  swl_pkg::cfg_t      cfg,
  output swl_pkg::state_t    st_nxt,
  output swl_pkg::out_word_t res
);

  logic [63:0] rtc_diff;
  logic        rtc_ge;
  logic        in_window;
  logic [7:0]  cnt_base;
  logic [7:0]  cnt_inc;
  logic [31:0] since_deadline;
  logic        gpio_wake;
  logic        mask_written;
  swl_pkg::state_t st_cnt;
  swl_pkg::state_t st_boot;
  logic [63:0] sensor_bit;

  // Window check: one shared subtract and compare
  assign rtc_diff  = item.rtc_ms - st.window_start;
  assign rtc_ge    = item.rtc_ms >= st.window_start;
  assign in_window = (st.window_start != 64'd0) && rtc_ge &&
                     (rtc_diff[63:32] == 32'd0) &&
                     (rtc_diff[31:0] <= cfg.window_length);

  // Count one spurious wake
  assign cnt_base = in_window ? st.wake_count : 8'd0;
  assign cnt_inc  = (cnt_base == swl_pkg::COUNT_MAX) ? cnt_base : cnt_base + 8'd1;

  always_comb begin
    st_cnt              = st;
    st_cnt.window_start = in_window ? st.window_start : item.rtc_ms;
    st_cnt.wake_count   = cnt_inc;
    if (cnt_inc >= cfg.spurious_limit) begin
      st_cnt.sensor_enabled = 1'b0;
    end
    st_cnt.pending  = 1'b0;
    st_cnt.deadline = 32'd0;
  end

  // Boot handling; cold boot wins over a pin wake
  assign gpio_wake = item.wake_by_gpio && !item.cold_boot;

  always_comb begin
    st_boot = st;
    if (!st.retained_valid || item.cold_boot) begin
      st_boot.retained_valid = 1'b1;
      st_boot.window_start   = 64'd0;
      st_boot.wake_count     = 8'd0;
      st_boot.sensor_enabled = 1'b1;
    end else if (st.sensor_enabled && (st.window_start != 64'd0) && !in_window) begin
      st_boot.wake_count   = 8'd0;
      st_boot.window_start = 64'd0;
    end
    st_boot.pending  = 1'b0;
    st_boot.deadline = 32'd0;
    if (item.barrel_held) begin
      st_boot.wake_count     = 8'd0;
      st_boot.window_start   = 64'd0;
      st_boot.sensor_enabled = 1'b1;
    end else if (gpio_wake && st_boot.sensor_enabled && item.sensor_asserted &&
                 !item.tip_held) begin
      st_boot.pending  = 1'b1;
      st_boot.deadline = item.now_ms + {16'd0, cfg.validation_time};
    end
  end

  assign since_deadline = item.now_ms - st.deadline;

  // Select the next state by event
  always_comb begin
    st_nxt       = st;
    mask_written = 1'b0;
    unique case (item.action)
      swl_pkg::ACT_BOOT: begin
        st_nxt       = st_boot;
        mask_written = 1'b1;
      end
      swl_pkg::ACT_TICK: begin
        if (st.pending && !since_deadline[31]) begin
          st_nxt       = st_cnt;
          mask_written = 1'b1;
        end
      end
      swl_pkg::ACT_MOTION, swl_pkg::ACT_BARREL: begin
        st_nxt.wake_count     = 8'd0;
        st_nxt.window_start   = 64'd0;
        st_nxt.sensor_enabled = 1'b1;
        st_nxt.pending        = 1'b0;
        st_nxt.deadline       = 32'd0;
        mask_written          = 1'b1;
      end
      swl_pkg::ACT_FAIL: begin
        if (st.pending) begin
          st_nxt       = st_cnt;
          mask_written = 1'b1;
        end
      end
      default: begin
        st_nxt       = st;
        mask_written = 1'b0;
      end
    endcase
  end

  // Build the result word from the updated state
  assign sensor_bit = 64'd1 << cfg.sensor_pin;

  always_comb begin
    res.wake_mask      = st_nxt.sensor_enabled ? cfg.wake_source_mask :
                         (cfg.wake_source_mask & ~sensor_bit);
    res.mask_written   = mask_written;
    res.sensor_wake_on = st_nxt.sensor_enabled;
    res.spurious_total = st_nxt.wake_count;
    res.check_pending  = st_nxt.pending;
  end

endmodule

/* hw/rtl/spurious_wake_limiter_top.sv */
// Spurious wake limiter: takes event words and returns exactly one result word per
// event, in order. An event is held in an input register, evaluated against the
// retained state in a single pass and written to the output register, which holds
// its result word until it is taken. The block sustains one word per cycle while
// the result side keeps taking words. The longest path is the 64-bit window
// subtract and compare feeding the counter update. Configuration writes land at once
// and should be made while no event is in flight.
module spurious_wake_limiter_top (
  input  logic        clk,
  input  logic        rst_n,
  swl_in_if.sink      in_chan,
  swl_out_if.source   out_chan,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [63:0] cfg_wdata
);

  `include "spurious_wake_limiter_top_assert.svh"

  swl_pkg::cfg_t      cfg_r;
  swl_pkg::state_t    st_r;
  swl_pkg::state_t    st_nxt;
  swl_pkg::in_word_t  s1_data_r;
  logic               s1_valid_r;
  swl_pkg::out_word_t out_data_r;
  swl_pkg::out_word_t res;
  logic               out_valid_r;
  logic               out_adv;
  logic               s1_fire;
  logic               in_fire;

  // Handshake flow
  assign out_adv       = !out_valid_r || out_chan.ready;
  assign s1_fire       = s1_valid_r && out_adv;
  assign in_chan.ready = !s1_valid_r || s1_fire;
  assign in_fire       = in_chan.valid && in_chan.ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wake_source_mask <= swl_pkg::RST_WAKE_MASK;
      cfg_r.sensor_pin       <= swl_pkg::RST_SENSOR_PIN;
      cfg_r.validation_time  <= swl_pkg::RST_VALID_TIME;
      cfg_r.spurious_limit   <= swl_pkg::RST_LIMIT;
      cfg_r.window_length    <= swl_pkg::RST_WINDOW;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        swl_pkg::CFG_WAKE_MASK:  cfg_r.wake_source_mask <= cfg_wdata;
        swl_pkg::CFG_SENSOR_PIN: cfg_r.sensor_pin       <= cfg_wdata[5:0];
        swl_pkg::CFG_VALID_TIME: cfg_r.validation_time  <= cfg_wdata[15:0];
        swl_pkg::CFG_LIMIT:      cfg_r.spurious_limit   <= cfg_wdata[7:0];
        swl_pkg::CFG_WINDOW:     cfg_r.window_length    <= cfg_wdata[31:0];
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  // Input register: capture an accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r <= in_chan.data;
    end
  end

  swl_step u_step (
    .item   (s1_data_r),
    .st     (st_r),
    .cfg    (cfg_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  // Retained state: advance when the event moves to the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.retained_valid <= 1'b0;
      st_r.window_start   <= 64'd0;
      st_r.wake_count     <= 8'd0;
      st_r.sensor_enabled <= 1'b1;
      st_r.pending        <= 1'b0;
      st_r.deadline       <= 32'd0;
    end else if (s1_fire) begin
      st_r <= st_nxt;
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data_r <= res;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  // Consistency checks on the retained state
  `SWL_ASSERT_SAME(a_disabled_counted, !st_r.sensor_enabled, st_r.wake_count != 8'd0, "sensor disabled with zero count")
  `SWL_ASSERT_SAME(a_pending_enabled, st_r.pending, st_r.sensor_enabled, "check pending while sensor disabled")
  `SWL_ASSERT_SAME(a_idle_deadline, !st_r.pending, st_r.deadline == 32'd0, "deadline left over with no check pending")
  `SWL_ASSERT_NEXT(a_motion_clears, s1_fire && (s1_data_r.action == swl_pkg::ACT_MOTION), out_data_r.sensor_wake_on && out_data_r.mask_written && (out_data_r.spurious_total == 8'd0), "motion did not clear the limiter")

endmodule

/* verif/tb_spurious_wake_limiter_top.sv */
module tb_spurious_wake_limiter_top;
  import swl_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SETTLE_CYCLES = 8;

  // Action codes the block leaves unused, and a register index with no register
  localparam logic [2:0] ACT_SPARE_LO = 3'd5;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;
  localparam logic [2:0] CFG_SPARE = 3'd7;

  // Boot pin patterns: {cold, gpio, barrel, tip, sensor}
  localparam logic [4:0] PINS_NONE = 5'b00000;
  localparam logic [4:0] PINS_SENSOR_WAKE = 5'b01001;
  localparam logic [4:0] PINS_COLD = 5'b11001;
  localparam logic [4:0] PINS_BARREL = 5'b01101;
  localparam logic [4:0] PINS_TIP = 5'b01011;

  // Shadow of the limiter: registers, retained state and the status words owed
  class limiter_shadow;
    cfg_t regs;
    state_t st;
    logic applied;
    out_word_t status_due[$];
    int unsigned faults;

    function new();
      regs.wake_source_mask = RST_WAKE_MASK;
      regs.sensor_pin = RST_SENSOR_PIN;
      regs.validation_time = RST_VALID_TIME;
      regs.spurious_limit = RST_LIMIT;
      regs.window_length = RST_WINDOW;
      st.retained_valid = 1'b0;
      st.window_start = '0;
      st.wake_count = '0;
      st.sensor_enabled = 1'b1;
      st.pending = 1'b0;
      st.deadline = '0;
      applied = 1'b0;
      faults = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] value);
      case (idx)
        CFG_WAKE_MASK:  regs.wake_source_mask = value;
        CFG_SENSOR_PIN: regs.sensor_pin = value[5:0];
        CFG_VALID_TIME: regs.validation_time = value[15:0];
        CFG_LIMIT:      regs.spurious_limit = value[7:0];
        CFG_WINDOW:     regs.window_length = value[31:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] mask_now();
      logic [63:0] m;
      m = regs.wake_source_mask;
      if (!st.sensor_enabled) m[regs.sensor_pin] = 1'b0;
      return m;
    endfunction

    function void drop_check();
      st.pending = 1'b0;
      st.deadline = '0;
    endfunction

    function void clear_all();
      st.wake_count = '0;
      st.window_start = '0;
      st.sensor_enabled = 1'b1;
      drop_check();
      applied = 1'b1;
    endfunction

    // Count one false wake, restarting the window when rtc falls outside it
    function void count_false(logic [63:0] rtc);
      logic in_win;
      in_win = 1'b0;
      if (st.window_start != 64'd0 && rtc >= st.window_start)
        in_win = (rtc - st.window_start) <= {32'd0, regs.window_length};
      if (!in_win) begin
        st.wake_count = '0;
        st.window_start = rtc;
      end
      if (st.wake_count != COUNT_MAX) st.wake_count = st.wake_count + 8'd1;
      if (st.wake_count >= regs.spurious_limit) st.sensor_enabled = 1'b0;
      drop_check();
      applied = 1'b1;
    endfunction

    function void boot(in_word_t w);
      logic gpio;
      gpio = w.wake_by_gpio && !w.cold_boot;
      if (!st.retained_valid || w.cold_boot) begin
        st.retained_valid = 1'b1;
        st.window_start = '0;
        st.wake_count = '0;
        st.sensor_enabled = 1'b1;
      end else if (st.sensor_enabled && st.window_start != 64'd0) begin
        if (w.rtc_ms < st.window_start ||
            (w.rtc_ms - st.window_start) > {32'd0, regs.window_length}) begin
          st.wake_count = '0;
          st.window_start = '0;
        end
      end
      applied = 1'b1;
      drop_check();
      if (w.barrel_held) begin
        clear_all();
      end else if (gpio && st.sensor_enabled && w.sensor_asserted && !w.tip_held) begin
        st.pending = 1'b1;
        st.deadline = w.now_ms + {16'd0, regs.validation_time};
      end
    endfunction

    // Advance the shadow by one accepted event word and queue its status
    function void take_event(in_word_t w);
      out_word_t want;
      logic [31:0] gap;
      applied = 1'b0;
      gap = w.now_ms - st.deadline;
      case (w.action)
        ACT_BOOT: boot(w);
        ACT_TICK: if (st.pending && !gap[31]) count_false(w.rtc_ms);
        ACT_MOTION, ACT_BARREL: clear_all();
        ACT_FAIL: if (st.pending) count_false(w.rtc_ms);
        default: ;
      endcase
      want.wake_mask = mask_now();
      want.mask_written = applied;
      want.sensor_wake_on = st.sensor_enabled;
      want.spurious_total = st.wake_count;
      want.check_pending = st.pending;
      status_due.push_back(want);
    endfunction

    function void match_status(out_word_t got);
      out_word_t want;
      if (status_due.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("unexpected status word: mask %h written %b on %b count %0d pending %b",
                   got.wake_mask, got.mask_written, got.sensor_wake_on,
                   got.spurious_total, got.check_pending);
      end else begin
        want = status_due.pop_front();
        if (got.wake_mask !== want.wake_mask || got.mask_written !== want.mask_written ||
            got.sensor_wake_on !== want.sensor_wake_on ||
            got.spurious_total !== want.spurious_total ||
            got.check_pending !== want.check_pending) begin
          faults++;
          if (faults <= 10)
            $display("status mismatch: expected mask %h written %b on %b count %0d pending %b",
                     want.wake_mask, want.mask_written, want.sensor_wake_on,
                     want.spurious_total, want.check_pending,
                     "; got mask %h written %b on %b count %0d pending %b",
                     got.wake_mask, got.mask_written, got.sensor_wake_on,
                     got.spurious_total, got.check_pending);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [2:0] cfg_idx;
  logic [63:0] cfg_wdata;

  swl_in_if in_chan();
  swl_out_if out_chan();

  spurious_wake_limiter_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  limiter_shadow book = new();
  bit calm = 1'b0;
  logic [31:0] now_t;
  logic [63:0] rtc_t;
  logic [15:0] vt_cur = RST_VALID_TIME;
  int unsigned cycles = 0;

  always #5 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("spurious_wake_limiter_top regression: fail");
      $finish;
    end
  end

  // Check each accepted status word, then pick the next ready level
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) book.match_status(out_chan.data);
    out_chan.ready <= calm || ($urandom_range(0, 99) >= 18);
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic in_word_t ev(logic [2:0] act, logic [31:0] now, logic [63:0] rtc,
                                  logic [4:0] pins);
    return {act, now, rtc, pins};
  endfunction

  // Offer one event word, idling now and then, and note it once taken
  task automatic send(input in_word_t w);
    while (!calm && $urandom_range(0, 99) < 18) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.data <= w;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    book.take_event(w);
  endtask

  // Drop valid and wait until every status word is back
  task automatic settle();
    in_chan.valid <= 1'b0;
    while (book.status_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_reg(input logic [2:0] idx, input logic [63:0] value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    book.write_reg(idx, value);
    if (idx == CFG_VALID_TIME) vt_cur = value[15:0];
  endtask

  task automatic configure(input logic [63:0] mask, input logic [5:0] pin,
                           input logic [15:0] vt, input logic [7:0] limit,
                           input logic [31:0] window, input bit spare);
    settle();
    set_reg(CFG_WAKE_MASK, mask);
    set_reg(CFG_SENSOR_PIN, {58'd0, pin});
    set_reg(CFG_VALID_TIME, {48'd0, vt});
    set_reg(CFG_LIMIT, {56'd0, limit});
    set_reg(CFG_WINDOW, {32'd0, window});
    if (spare) set_reg(CFG_SPARE, rand64());
    cfg_we <= 1'b0;
  endtask

  // Mostly sensor wakes followed by ticks and failures, with noise mixed in
  task automatic run_mix(input int unsigned n, input int unsigned span);
    int unsigned done;
    int unsigned r;
    in_word_t w;
    logic [4:0] pins;
    done = 0;
    while (done < n) begin
      r = $urandom_range(0, 99);
      rtc_t = rtc_t + $urandom_range(0, span);
      if (r < 30) begin
        now_t = now_t + $urandom_range(0, 50);
        pins = ($urandom_range(0, 9) == 0) ? 5'($urandom) : PINS_SENSOR_WAKE;
        w = ev(ACT_BOOT, now_t, rtc_t, pins);
      end else if (r < 58) begin
        now_t = now_t + $urandom_range(0, vt_cur / 2 + 2);
        w = ev(ACT_TICK, now_t, rtc_t, 5'($urandom));
      end else if (r < 70) begin
        w = ev(ACT_FAIL, now_t, rtc_t, 5'($urandom));
      end else if (r < 78) begin
        w = ev(ACT_BOOT, now_t, rtc_t, 5'($urandom));
      end else if (r < 84) begin
        w = ev($urandom_range(0, 1) ? ACT_MOTION : ACT_BARREL, now_t, rtc_t, 5'($urandom));
      end else if (r < 92) begin
        w = ev(3'($urandom_range(ACT_BOOT, ACT_FAIL)), $urandom, rand64(), 5'($urandom));
        if ($urandom_range(0, 1)) begin
          now_t = w.now_ms;
          rtc_t = w.rtc_ms;
        end
      end else begin
        w = ev(3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI)), $urandom, rand64(),
               5'($urandom));
      end
      send(w);
      if (r < 92) done++;
    end
  endtask

  // Drive the count up to a limit of 255 with back-to-back false wakes
  task automatic run_saturation(input int unsigned pairs);
    int unsigned i;
    rtc_t = 64'd1;
    send(ev(ACT_MOTION, now_t, rtc_t, PINS_NONE));
    for (i = 0; i < pairs; i++) begin
      rtc_t = rtc_t + $urandom_range(1, 1000);
      now_t = now_t + $urandom_range(0, 50);
      send(ev(ACT_BOOT, now_t, rtc_t, PINS_SENSOR_WAKE));
      if ($urandom_range(0, 1)) begin
        send(ev(ACT_FAIL, now_t, rtc_t, PINS_NONE));
      end else begin
        now_t = now_t + {16'd0, vt_cur} + $urandom_range(0, 3);
        send(ev(ACT_TICK, now_t, rtc_t, PINS_NONE));
      end
    end
    send(ev(ACT_BARREL, now_t, rtc_t, PINS_NONE));
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_WAKE_MASK;
    cfg_wdata = '0;
    in_chan.valid = 1'b0;
    in_chan.data = '0;
    out_chan.ready = 1'b0;
    now_t = '0;
    rtc_t = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Nothing pending yet, and the unused actions
    send(ev(ACT_TICK, 32'd0, 64'd0, PINS_NONE));
    send(ev(ACT_FAIL, '1, '1, 5'b11111));
    send(ev(ACT_SPARE_LO, '1, '1, 5'b11111));
    send(ev(ACT_SPARE_HI, 32'd0, 64'd0, PINS_NONE));

    configure('1, 6'd0, 16'hFFFF, 8'd2, '1, 1'b0);
    // Cold boot wins over a pin wake
    send(ev(ACT_BOOT, 32'd0, 64'd0, PINS_COLD));
    // Deadline wraps past zero; one short of it, then exactly on it
    send(ev(ACT_BOOT, 32'hFFFF_FF00, 64'd1000, PINS_SENSOR_WAKE));
    send(ev(ACT_TICK, 32'h0000_FEFE, 64'd1000, PINS_NONE));
    send(ev(ACT_TICK, 32'h0000_FEFF, 64'd1000, PINS_NONE));
    // Second false wake in the window reaches the limit
    send(ev(ACT_BOOT, 32'd5, 64'd2000, PINS_SENSOR_WAKE));
    send(ev(ACT_FAIL, 32'd5, 64'd2000, PINS_NONE));
    send(ev(ACT_BOOT, 32'd6, 64'd2100, PINS_SENSOR_WAKE));
    send(ev(ACT_TICK, '1, 64'd2100, PINS_NONE));
    send(ev(ACT_MOTION, 32'd7, 64'd2200, PINS_NONE));
    send(ev(ACT_BOOT, 32'd8, 64'd2300, PINS_BARREL));
    send(ev(ACT_BOOT, 32'd9, 64'd2400, PINS_TIP));
    // Clock running backward against the window start
    send(ev(ACT_BOOT, 32'd10, 64'd500, PINS_SENSOR_WAKE));
    send(ev(ACT_FAIL, 32'd10, 64'd400, PINS_NONE));
    send(ev(ACT_BOOT, 32'd11, 64'd300, PINS_SENSOR_WAKE));
    send(ev(ACT_BARREL, 32'd12, 64'd300, PINS_NONE));

    // Zero limit: the first false wake disables the sensor
    configure(rand64(), 6'd63, 16'd0, 8'd0, 32'd0, 1'b0);
    send(ev(ACT_BOOT, 32'd7, 64'd1, PINS_SENSOR_WAKE));
    send(ev(ACT_TICK, 32'd7, 64'd1, PINS_NONE));

    // Random phases across register settings
    configure(rand64(), 6'($urandom), RST_VALID_TIME, RST_LIMIT, RST_WINDOW, 1'b0);
    run_mix(250, 12000);

    configure('1, 6'd63, 16'd0, 8'd1, 32'd0, 1'b0);
    calm = 1'b1;
    run_mix(200, 2);
    calm = 1'b0;

    configure(64'd0, 6'd0, 16'hFFFF, 8'd0, '1, 1'b0);
    run_mix(150, 1 << 20);

    configure(rand64(), 6'($urandom), 16'($urandom_range(0, 500)), 8'hFF, '1, 1'b0);
    run_saturation(265);

    configure(rand64(), 6'($urandom), 16'($urandom), 8'($urandom_range(1, 6)),
              32'($urandom_range(0, 100000)), 1'b1);
    run_mix(200, 40000);

    // Wait out the last words, then give the pipeline time to misbehave
    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (book.faults == 0 && book.status_due.size() == 0)
      $display("spurious_wake_limiter_top regression: pass");
    else
      $display("spurious_wake_limiter_top regression: fail");
    $finish;
  end

endmodule
